>>> rtl/rtp_reorder_nack_requester_assert.svh
// assertion macros shared by the reorder nack requester rtl
`ifndef RTP_REORDER_NACK_REQUESTER_ASSERT_SVH
`define RTP_REORDER_NACK_REQUESTER_ASSERT_SVH
`ifndef SYNTH
`define RNR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rnr assertion failed");
`define RNR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rnr assertion failed");
`else
`define RNR_ASSERT_IMP(label, ante, cons)
`define RNR_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> rtl/rnr_pkg.sv
// types, codes and constants of the rtp reorder nack requester
`default_nettype none
package rnr_pkg;
	localparam int SEQ_W   = 16;
	localparam int TIME_W  = 32;
	localparam int JIT_W   = 7;
	localparam int IVL_W   = 16;
	localparam int RMAX_W  = 8;
	localparam int SRC_W   = 32;
	localparam int CFG_W   = 32;
	localparam int RES_CAP = 64;
	localparam int NCNT_W  = 7;

	localparam logic [1:0] CMD_MEDIA = 2'd0;
	localparam logic [1:0] CMD_PASS  = 2'd1;

	localparam logic [JIT_W-1:0]  JIT_RST  = 7'd16;
	localparam logic [IVL_W-1:0]  IVL_RST  = 16'd10;
	localparam logic [RMAX_W-1:0] RMAX_RST = 8'd10;

	typedef enum logic [1:0] {
		CLS_MEDIA,
		CLS_PASS,
		CLS_TICK
	} cls_t;

	typedef enum logic [1:0] {
		KIND_DELIVER,
		KIND_PASS,
		KIND_NACK
	} kind_t;

	typedef enum logic [1:0] {
		CFG_JITTER,
		CFG_INTERVAL,
		CFG_RESEND_MAX,
		CFG_SOURCE
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROC,
		ST_DRAIN,
		ST_DELIVER,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [JIT_W-1:0]  jitter_size;
		logic [IVL_W-1:0]  interval;
		logic [RMAX_W-1:0] resend_max;
		logic [SRC_W-1:0]  source_id;
	} cfg_t;

	typedef struct packed {
		logic item_pop;
		logic res_push;
	} back_ctl_t;

	// unused command codes behave as a tick
	function automatic cls_t classify(input logic [1:0] cmd);
		cls_t c;
		unique case (cmd)
			CMD_MEDIA: c = CLS_MEDIA;
			CMD_PASS:  c = CLS_PASS;
			default:   c = CLS_TICK;
		endcase
		return c;
	endfunction
endpackage
`default_nettype wire

>>> rtl/rnr_ram.sv
// generic single write port ram with registered read
`default_nettype none
module rnr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

>>> rtl/rnr_fifo.sv
// small register queue used on both sides of the block
`default_nettype none
module rnr_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/rnr_front.sv
// front end: accepts items, classifies the command and queues them
`default_nettype none
module rnr_front
	import rnr_pkg::*;
#(
	parameter int HANDLE_BITS = 16,
	parameter int QDEPTH      = 4
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic [1:0]             command,
	input  wire logic [SEQ_W-1:0]       seq,
	input  wire logic [HANDLE_BITS-1:0] packet_handle,
	input  wire logic [TIME_W-1:0]      now_ms,
	input  wire logic                   item_pop,
	output logic                        item_valid,
	output cls_t                        item_cls,
	output logic      [SEQ_W-1:0]       item_seq,
	output logic      [HANDLE_BITS-1:0] item_handle,
	output logic      [TIME_W-1:0]      item_now
);
	localparam int IW = 2 + SEQ_W + HANDLE_BITS + TIME_W;

	cls_t          cls_in;
	logic [IW-1:0] wdata, rdata;
	logic [1:0]    cls_bits;
	logic          empty;

	assign cls_in = classify(command);
	assign wdata  = {cls_in, seq, packet_handle, now_ms};

	rnr_fifo #(
		.WIDTH(IW),
		.DEPTH(QDEPTH)
	) u_item_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (wdata),
		.full  (full),
		.pop   (item_pop),
		.rdata (rdata),
		.empty (empty)
	);

	assign {cls_bits, item_seq, item_handle, item_now} = rdata;
	assign item_cls   = cls_t'(cls_bits);
	assign item_valid = !empty;
endmodule
`default_nettype wire

>>> rtl/rnr_back.sv
// back end: slot store, in-order drain, nack and give-up sequencer
`default_nettype none
module rnr_back
	import rnr_pkg::*;
#(
	parameter int DEPTH       = 64,
	parameter int HANDLE_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cfg_t                   cfg,
	input  wire logic                   item_valid,
	input  wire cls_t                   item_cls,
	input  wire logic [SEQ_W-1:0]       item_seq,
	input  wire logic [HANDLE_BITS-1:0] item_handle,
	input  wire logic [TIME_W-1:0]      item_now,
	input  wire logic                   res_full,
	output back_ctl_t                   ctl,
	output kind_t                       res_kind,
	output logic      [HANDLE_BITS-1:0] res_handle,
	output logic      [SEQ_W-1:0]       res_seq,
	output logic      [SRC_W-1:0]       res_src,
	output logic                        res_last
);
	// stored sequences always lie within DEPTH of expected, so the low
	// bits of seq are a unique slot index even when DEPTH is not a power of two
	localparam int AW    = $clog2(DEPTH);
	localparam int NSLOT = 1 << AW;
	localparam int CW    = AW + 1;

	state_t state_q, state_d;

	cls_t                   cls_q;
	logic [SEQ_W-1:0]       seq_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [TIME_W-1:0]      now_q;

	logic              started_q;
	logic [SEQ_W-1:0]  exp_q;
	logic [CW-1:0]     count_q;
	logic [NSLOT-1:0]  valid_q;
	logic [RMAX_W-1:0] resend_q;
	logic [TIME_W-1:0] next_q;
	logic              armed_q;
	logic [NCNT_W-1:0] ncnt_q;

	logic                   pend_v_q;
	kind_t                  pend_kind_q;
	logic [HANDLE_BITS-1:0] pend_handle_q;
	logic [SEQ_W-1:0]       pend_seq_q;
	logic [SRC_W-1:0]       pend_src_q;

	logic [SEQ_W-1:0]       exp_eff, diff;
	logic                   in_win, passed;
	logic [TIME_W-1:0]      d_time;
	logic [AW-1:0]          slot_in, slot_e;
	logic [HANDLE_BITS-1:0] rd_handle;

	logic                   take, media, store, produce, deliver, give_up, nack, finish;
	kind_t                  new_kind;
	logic [HANDLE_BITS-1:0] new_handle;
	logic [SEQ_W-1:0]       new_seq;
	logic [SRC_W-1:0]       new_src;

	assign exp_eff = started_q ? exp_q : seq_q;
	assign diff    = seq_q - exp_eff;
	assign in_win  = diff < SEQ_W'(DEPTH);
	assign slot_in = seq_q[AW-1:0];
	assign slot_e  = exp_q[AW-1:0];
	assign d_time  = now_q - next_q;
	// wrapped time compare: strictly later means a positive nonzero difference
	assign passed  = !armed_q || (d_time != '0 && !d_time[TIME_W-1]);

	rnr_ram #(
		.WIDTH(HANDLE_BITS),
		.DEPTH(NSLOT)
	) u_slot_ram (
		.clk  (clk),
		.we   (store),
		.waddr(slot_in),
		.wdata(handle_q),
		.raddr(slot_e),
		.rdata(rd_handle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		take       = 1'b0;
		media      = 1'b0;
		store      = 1'b0;
		produce    = 1'b0;
		deliver    = 1'b0;
		give_up    = 1'b0;
		nack       = 1'b0;
		finish     = 1'b0;
		new_kind   = KIND_PASS;
		new_handle = handle_q;
		new_seq    = '0;
		new_src    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					take    = 1'b1;
					state_d = ST_PROC;
				end
			end
			ST_PROC: begin
				if (!res_full) begin
					media   = (cls_q == CLS_MEDIA);
					store   = media && in_win;
					produce = (cls_q == CLS_PASS);
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!res_full) begin
					if (count_q == '0 || ncnt_q == NCNT_W'(RES_CAP)) begin
						state_d = ST_FINISH;
					end else if (valid_q[slot_e]) begin
						state_d = ST_DELIVER;
					end else begin
						state_d = ST_FINISH;
						if (32'(count_q) >= 32'(cfg.jitter_size)) begin
							if (resend_q >= cfg.resend_max) begin
								give_up = 1'b1;
							end else if (passed) begin
								nack       = 1'b1;
								produce    = 1'b1;
								new_kind   = KIND_NACK;
								new_handle = '0;
								new_seq    = exp_q;
								new_src    = cfg.source_id;
							end
						end
					end
				end
			end
			ST_DELIVER: begin
				if (!res_full) begin
					deliver    = 1'b1;
					produce    = 1'b1;
					new_kind   = KIND_DELIVER;
					new_handle = rd_handle;
					new_seq    = exp_q;
					state_d    = ST_DRAIN;
				end
			end
			ST_FINISH: begin
				if (!res_full) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cls_q    <= item_cls;
			seq_q    <= item_seq;
			handle_q <= item_handle;
			now_q    <= item_now;
		end
		if (produce) begin
			pend_kind_q   <= new_kind;
			pend_handle_q <= new_handle;
			pend_seq_q    <= new_seq;
			pend_src_q    <= new_src;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			exp_q     <= '0;
			count_q   <= '0;
			valid_q   <= '0;
			resend_q  <= '0;
			next_q    <= '0;
			armed_q   <= 1'b0;
			ncnt_q    <= '0;
			pend_v_q  <= 1'b0;
		end else begin
			if (media) begin
				started_q <= 1'b1;
				if (!started_q) begin
					exp_q <= seq_q;
				end
			end
			if (store) begin
				valid_q[slot_in] <= 1'b1;
				if (!valid_q[slot_in]) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (deliver) begin
				valid_q[slot_e] <= 1'b0;
				count_q         <= count_q - 1'b1;
				exp_q           <= exp_q + 1'b1;
				resend_q        <= '0;
			end
			if (give_up) begin
				started_q <= 1'b0;
				count_q   <= '0;
				valid_q   <= '0;
				resend_q  <= '0;
				next_q    <= now_q;
				armed_q   <= 1'b1;
			end
			if (nack) begin
				next_q  <= now_q + TIME_W'(cfg.interval);
				armed_q <= 1'b1;
				if (resend_q != '1) begin
					resend_q <= resend_q + 1'b1;
				end
			end
			// one result is held back so the last flag is known on transfer
			if (produce) begin
				pend_v_q <= 1'b1;
				ncnt_q   <= ncnt_q + 1'b1;
			end else if (finish) begin
				pend_v_q <= 1'b0;
				ncnt_q   <= '0;
			end
		end
	end

	assign ctl.item_pop = take;
	assign ctl.res_push = (produce || finish) && pend_v_q;
	assign res_kind     = pend_kind_q;
	assign res_handle   = pend_handle_q;
	assign res_seq      = pend_seq_q;
	assign res_src      = pend_src_q;
	assign res_last     = finish;
endmodule
`default_nettype wire

>>> rtl/rtp_reorder_nack_requester.sv
// Top level of the RTP reorder buffer with NACK requests.
// Each item passes through the back-end sequencer states take, process, drain check and
// finish; each packet released adds a deliver state and a further drain check, set by the
// slot RAM registered read. Input and result queues of 4 entries let both sides run while
// the sequencer works.
// arst_n clears all control state, empties the slots and loads register defaults.
`default_nettype none
`include "rtp_reorder_nack_requester_assert.svh"
module rtp_reorder_nack_requester
	import rnr_pkg::*;
#(
	parameter int DEPTH       = 64,
	parameter int HANDLE_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_wr,
	input  wire logic [1:0]             cfg_idx,
	input  wire logic [CFG_W-1:0]       cfg_data,
	input  wire logic                   push,
	output logic                        full,
	input  wire logic [1:0]             command,
	input  wire logic [SEQ_W-1:0]       seq,
	input  wire logic [HANDLE_BITS-1:0] packet_handle,
	input  wire logic [TIME_W-1:0]      now_ms,
	output logic                        empty,
	input  wire logic                   pop,
	output logic      [1:0]             kind,
	output logic      [HANDLE_BITS-1:0] packet_handle_res,
	output logic      [SEQ_W-1:0]       seq_res,
	output logic      [SRC_W-1:0]       nack_source,
	output logic                        last
);
	localparam int QDEPTH = 4;
	localparam int RW     = 2 + HANDLE_BITS + SEQ_W + SRC_W + 1;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.jitter_size <= JIT_RST;
			cfg_q.interval    <= IVL_RST;
			cfg_q.resend_max  <= RMAX_RST;
			cfg_q.source_id   <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_idx_t'(cfg_idx))
				CFG_JITTER:     cfg_q.jitter_size <= cfg_data[JIT_W-1:0];
				CFG_INTERVAL:   cfg_q.interval    <= cfg_data[IVL_W-1:0];
				CFG_RESEND_MAX: cfg_q.resend_max  <= cfg_data[RMAX_W-1:0];
				CFG_SOURCE:     cfg_q.source_id   <= cfg_data[SRC_W-1:0];
				default:        ;
			endcase
		end
	end

	logic                   item_valid;
	cls_t                   item_cls;
	logic [SEQ_W-1:0]       item_seq;
	logic [HANDLE_BITS-1:0] item_handle;
	logic [TIME_W-1:0]      item_now;
	back_ctl_t              ctl;

	kind_t                  res_kind;
	logic [HANDLE_BITS-1:0] res_handle;
	logic [SEQ_W-1:0]       res_seq;
	logic [SRC_W-1:0]       res_src;
	logic                   res_last;
	logic [RW-1:0]          o_wdata, o_rdata;
	logic                   o_full;

	rnr_front #(
		.HANDLE_BITS(HANDLE_BITS),
		.QDEPTH     (QDEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.command      (command),
		.seq          (seq),
		.packet_handle(packet_handle),
		.now_ms       (now_ms),
		.item_pop     (ctl.item_pop),
		.item_valid   (item_valid),
		.item_cls     (item_cls),
		.item_seq     (item_seq),
		.item_handle  (item_handle),
		.item_now     (item_now)
	);

	rnr_back #(
		.DEPTH      (DEPTH),
		.HANDLE_BITS(HANDLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_cls   (item_cls),
		.item_seq   (item_seq),
		.item_handle(item_handle),
		.item_now   (item_now),
		.res_full   (o_full),
		.ctl        (ctl),
		.res_kind   (res_kind),
		.res_handle (res_handle),
		.res_seq    (res_seq),
		.res_src    (res_src),
		.res_last   (res_last)
	);

	assign o_wdata = {res_kind, res_handle, res_seq, res_src, res_last};

	rnr_fifo #(
		.WIDTH(RW),
		.DEPTH(QDEPTH)
	) u_res_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (ctl.res_push),
		.wdata (o_wdata),
		.full  (o_full),
		.pop   (pop),
		.rdata (o_rdata),
		.empty (empty)
	);

	assign {kind, packet_handle_res, seq_res, nack_source, last} = o_rdata;

	`RNR_ASSERT_IMP(a_res_no_overflow, ctl.res_push, !o_full)
	`RNR_ASSERT_IMP(a_item_no_underflow, ctl.item_pop, item_valid)
	`RNR_ASSERT_NXT(a_res_lands, ctl.res_push && !o_full, !empty)
endmodule
`default_nettype wire
